[hdl/hsvbl_pkg.sv]
package hsvbl_pkg;

  localparam int unsigned SECTOR_W = 12;
  localparam logic [SECTOR_W-1:0] SECTOR = 12'd3840;
  localparam logic [14:0] HUE_MAX = 15'd23039;
  localparam logic [14:0] HUE_S1 = 15'd3840;
  localparam logic [14:0] HUE_S2 = 15'd7680;
  localparam logic [14:0] HUE_S3 = 15'd11520;
  localparam logic [14:0] HUE_S4 = 15'd15360;
  localparam logic [14:0] HUE_S5 = 15'd19200;
  localparam logic [6:0] RAMP_NUM = 7'd98;
  localparam logic [27:0] FULL_LEVEL = 28'd251658240;
  localparam logic [15:0] BRIGHT_RESET = 16'd32768;
  localparam logic [15:0] MAX_RESET = 16'd65535;
  localparam logic [7:0] ONE_RESET = 8'd248;
  localparam logic [7:0] ZERO_RESET = 8'd192;
  localparam logic [4:0] LAST_BIT = 5'd23;
  localparam logic [12:0] DIV15_MUL = 13'd4370;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS_MAX = 2'd0,
    REG_BREATHING_EN   = 2'd1,
    REG_ONE_SYMBOL     = 2'd2,
    REG_ZERO_SYMBOL    = 2'd3
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RAMP = 8'b0000_0010,
    ST_PREP = 8'b0000_0100,
    ST_MUL1 = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_PACK = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       ramp;
    logic       prep;
    logic       mul1;
    logic       mul2;
    logic       div;
    logic       pack;
    logic       shift;
  } dp_cmd_t;

endpackage

[hdl/hsv_breathing_led_spi_encoder.sv]
// After an input transaction the controller runs the ramp step, the prep stage, the
// multiply stages, the divide stage and the pack step before the first symbol byte is
// offered. Each item is sent as 24 output bytes, each held until the sink takes it.
// One item is in flight at a time; input is ready only while idle.
// Reset (rst_ni low, asynchronous): control, configuration and brightness registers take
// their reset values (datapath registers have none), brightness goes to one half and the ramp direction to up.
module hsv_breathing_led_spi_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // hue[14:0] saturation[30:15] advance[31] key_index[38:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // symbol[7:0]
  output logic [6:0]  m_axis_tuser,   // key_tag[6:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hsvbl_pkg::*;

  dp_cmd_t cmd;

  hsvbl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_o         (cmd)
  );

  hsvbl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .s_axis_tdata (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

[hdl/hsvbl_ctrl.sv]
module hsvbl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic              m_axis_tlast,
  output hsvbl_pkg::dp_cmd_t cmd_o
);
  import hsvbl_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       in_fire, out_fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tlast  = m_axis_tvalid && (cnt_q == LAST_BIT);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        cmd_o.ramp = 1'b1;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d = ST_PACK;
      end
      ST_PACK: begin
        cmd_o.pack = 1'b1;
        cnt_d = 5'd0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd_o.shift = 1'b1;
          if (cnt_q == LAST_BIT) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_RAMP)
    else $error("accepted transaction did not start the ramp step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while output pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && m_axis_tlast |=> state_q == ST_IDLE)
    else $error("last byte did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q <= LAST_BIT)
    else $error("byte counter out of range");
`endif

endmodule

[hdl/hsvbl_dp.sv]
module hsvbl_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsvbl_pkg::dp_cmd_t cmd_i,
  input  logic [39:0]        s_axis_tdata,   // hue[14:0] saturation[30:15] advance[31] key_index[38:32]
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic [7:0]         m_axis_tdata,   // symbol[7:0]
  output logic [6:0]         m_axis_tuser    // key_tag[6:0]
);
  import hsvbl_pkg::*;

  logic [15:0] max_q;
  logic        en_q;
  logic [7:0]  one_q, zero_q;
  logic [15:0] bright_q;
  logic        down_q;

  logic [14:0] hue_q;
  logic [15:0] sat_q;
  logic        adv_q;
  logic [6:0]  tag_q;
  logic [2:0]  sector_q;
  logic [11:0] d_q;
  logic [23:0] bb_q;
  logic [27:0] part_q;
  logic [11:0] rem_q;
  logic [7:0]  nch_q, quo_q;
  logic [23:0] bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_RESET;
      en_q   <= 1'b0;
      one_q  <= ONE_RESET;
      zero_q <= ZERO_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BRIGHTNESS_MAX: max_q  <= cfg_data_i;
        REG_BREATHING_EN:   en_q   <= cfg_data_i[0];
        REG_ONE_SYMBOL:     one_q  <= cfg_data_i[7:0];
        REG_ZERO_SYMBOL:    zero_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [22:0]        step_prod;
  logic [6:0]         step;
  logic signed [17:0] v, mx;
  logic [15:0]        bright_d;
  logic               down_d;

  always_comb begin
    step_prod = 23'(max_q) * 23'(RAMP_NUM);
    step      = step_prod[22:16];
    mx        = $signed({2'b00, max_q});
    bright_d  = bright_q;
    down_d    = down_q;
    if (en_q) begin
      v = down_q ? $signed({2'b00, bright_q}) - $signed({11'd0, step})
                 : $signed({2'b00, bright_q}) + $signed({11'd0, step});
    end else begin
      v = mx;
    end
    if (v > mx) begin
      bright_d = max_q;
      if (en_q) down_d = 1'b1;
    end else if (v < 18'sd0) begin
      bright_d = 16'd0;
      if (en_q) down_d = 1'b0;
    end else begin
      bright_d = v[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RESET;
      down_q   <= 1'b0;
    end else if (cmd_i.ramp && adv_q) begin
      bright_q <= bright_d;
      down_q   <= down_d;
    end
  end

  logic [14:0] hue_c;
  logic [2:0]  sector_d;
  logic [12:0] t;
  logic [11:0] d_d;

  always_comb begin
    hue_c = (hue_q > HUE_MAX) ? HUE_MAX : hue_q;
    if (hue_c >= HUE_S5)      sector_d = 3'd5;
    else if (hue_c >= HUE_S4) sector_d = 3'd4;
    else if (hue_c >= HUE_S3) sector_d = 3'd3;
    else if (hue_c >= HUE_S2) sector_d = 3'd2;
    else if (hue_c >= HUE_S1) sector_d = 3'd1;
    else                      sector_d = 3'd0;
    if (hue_c >= HUE_S4)      t = 13'(hue_c - HUE_S4);
    else if (hue_c >= HUE_S2) t = 13'(hue_c - HUE_S2);
    else                      t = hue_c[12:0];
    d_d = (t >= 13'(SECTOR)) ? 12'(t - 13'(SECTOR)) : 12'(13'(SECTOR) - t);
  end

  logic [51:0] pprod;
  logic [40:0] nprod;
  logic [23:0] qprod;
  logic [16:0] sat_inv;
  logic [7:0]  fch, rch, gch, bch;

  // divide by 3840 as a shift by 8 and a reciprocal multiply by 1/15
  assign sat_inv = 17'h10000 - 17'(sat_q);
  assign pprod   = 52'(part_q) * 52'(bb_q);
  assign nprod   = 41'(sat_inv) * 41'(bb_q);
  assign qprod   = 24'(rem_q) * 24'(DIV15_MUL);
  assign fch     = bb_q[23:16];

  always_comb begin
    case (sector_q)
      3'd0:    begin rch = fch;   gch = quo_q; bch = nch_q; end
      3'd1:    begin rch = quo_q; gch = fch;   bch = nch_q; end
      3'd2:    begin rch = nch_q; gch = fch;   bch = quo_q; end
      3'd3:    begin rch = nch_q; gch = quo_q; bch = fch;   end
      3'd4:    begin rch = quo_q; gch = nch_q; bch = fch;   end
      default: begin rch = fch;   gch = nch_q; bch = quo_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hue_q <= s_axis_tdata[14:0];
      sat_q <= s_axis_tdata[30:15];
      adv_q <= s_axis_tdata[31];
      tag_q <= s_axis_tdata[38:32];
    end
    if (cmd_i.prep) begin
      sector_q <= sector_d;
      d_q      <= d_d;
      bb_q     <= {bright_q, 8'd0} - 24'(bright_q);
    end
    if (cmd_i.mul1) begin
      part_q <= FULL_LEVEL - 28'(28'(sat_q) * 28'(d_q));
    end
    if (cmd_i.mul2) begin
      rem_q <= pprod[51:40];
      nch_q <= nprod[39:32];
    end
    if (cmd_i.div) begin
      quo_q <= qprod[23:16];
    end
    if (cmd_i.pack) begin
      bits_q <= {gch, rch, bch};
    end else if (cmd_i.shift) begin
      bits_q <= {bits_q[22:0], 1'b0};
    end
  end

  assign m_axis_tdata = bits_q[23] ? one_q : zero_q;
  assign m_axis_tuser = tag_q;

endmodule
